FILE: rtl/core/biquadratic_julia_escape_time_unit_macros.svh
// assertion helpers shared by the escape-time unit
// all macros sample on clk_i and are disabled while rst_ni is low
`ifndef BIQUADRATIC_JULIA_ESCAPE_TIME_UNIT_MACROS_SVH
`define BIQUADRATIC_JULIA_ESCAPE_TIME_UNIT_MACROS_SVH

// same-cycle implication
`define BJET_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BJET_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bjet_pkg.sv
package bjet_pkg;

  // field and register widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned IterW  = 12;
  localparam int unsigned ResW   = 16;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned KW     = CoordW + 2;
  localparam int unsigned CfgAddrW = 3;

  // escape radius squared, result scale and doubling factor
  localparam int unsigned EscRadiusSq = 10;
  localparam int unsigned EscScale    = 5;
  localparam int unsigned CrossScale  = 2;

  localparam logic [IterW-1:0] MaxIterReset = IterW'(100);

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_D_REAL   = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_D_IMAG   = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_C_REAL   = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_C_IMAG   = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_MAX_ITER = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_STEP_A,
    ST_MUL_B,
    ST_STEP_B,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step_a;
    logic step_b;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lim;
    logic esc;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/core/bjet_ctrl.sv
module bjet_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bjet_pkg::sts_t  sts_i,
  output bjet_pkg::cmd_t  cmd_o
);
  import bjet_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        state_d = sts_i.lim ? ST_FIN : ST_STEP_A;
      end
      ST_STEP_A: begin
        state_d = sts_i.esc ? ST_FIN : ST_MUL_B;
      end
      ST_MUL_B: begin
        state_d = ST_STEP_B;
      end
      ST_STEP_B: begin
        state_d = ST_MUL_A;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL_A, ST_MUL_B: begin
        cmd_o.mul = 1'b1;
      end
      ST_STEP_A: begin
        cmd_o.step_a = !sts_i.esc;
      end
      ST_STEP_B: begin
        cmd_o.step_b = 1'b1;
      end
      ST_FIN: begin
        cmd_o.push = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `include "biquadratic_julia_escape_time_unit_macros.svh"

  `BJET_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_MUL_A, "accept did not start iteration")
  `BJET_ASSERT_SAME(a_step_b_order, state_q == ST_STEP_B, $past(state_q) == ST_MUL_B, "second half-step without products")
  `BJET_ASSERT_NEXT(a_fin_drains, state_q == ST_FIN && !sts_i.out_busy, state_q == ST_IDLE, "result not handed over")
  `BJET_ASSERT_NEXT(a_limit_ends, state_q == ST_MUL_A && sts_i.lim, state_q == ST_FIN, "step limit not honored")

endmodule

FILE: rtl/core/bjet_dp.sv
module bjet_dp #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bjet_pkg::cmd_t                        cmd_i,
  output bjet_pkg::sts_t                        sts_o,
  input  logic signed [bjet_pkg::CoordW-1:0]    z_real_i,
  input  logic signed [bjet_pkg::CoordW-1:0]    z_imag_i,
  input  logic signed [bjet_pkg::CoordW-1:0]    d_real_i,
  input  logic signed [bjet_pkg::CoordW-1:0]    d_imag_i,
  input  logic signed [bjet_pkg::CoordW-1:0]    c_real_i,
  input  logic signed [bjet_pkg::CoordW-1:0]    c_imag_i,
  input  logic [bjet_pkg::IterW-1:0]            max_iter_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bjet_pkg::ResW-1:0]      escape_value_o
);
  import bjet_pkg::*;

  localparam logic signed [ProdW-1:0] Limit = ProdW'(EscRadiusSq) << FRAC_BITS;
  localparam logic signed [ProdW-1:0] SatMax = ProdW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic signed [ProdW-1:0] SatMin = -SatMax - ProdW'(1);

  logic signed [CoordW-1:0] z_re_q, z_re_d, z_im_q, z_im_d;
  logic signed [KW-1:0]     ka_re_q, ka_im_q, kb_re_q, kb_im_q;
  logic signed [ProdW-1:0]  p_rr_q, p_ii_q, p_ri_q;
  logic [IterW-1:0]         cnt_q;
  logic                     out_valid_q;
  logic signed [ResW-1:0]   out_data_q;

  logic signed [ProdW-1:0]  r2, i2, ri, sq_sum, k_re, k_im, nre, nim;
  logic signed [ResW-1:0]   res;

  // constants a = c + d and b = conj(c) + 2d, latched per point
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ka_re_q <= KW'(c_real_i) + KW'(d_real_i);
      ka_im_q <= KW'(c_imag_i) + KW'(d_imag_i);
      kb_re_q <= KW'(c_real_i) + KW'(CrossScale) * KW'(d_real_i);
      kb_im_q <= KW'(CrossScale) * KW'(d_imag_i) - KW'(c_imag_i);
    end
  end

  // three parallel 32x32 products of the current z
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_rr_q <= ProdW'(z_re_q) * ProdW'(z_re_q);
      p_ii_q <= ProdW'(z_im_q) * ProdW'(z_im_q);
      p_ri_q <= ProdW'(z_re_q) * ProdW'(z_im_q);
    end
  end

  // floor shift, escape test and half-step update
  always_comb begin
    r2     = p_rr_q >>> FRAC_BITS;
    i2     = p_ii_q >>> FRAC_BITS;
    ri     = p_ri_q >>> FRAC_BITS;
    sq_sum = r2 + i2;
    k_re   = cmd_i.step_b ? ProdW'(kb_re_q) : ProdW'(ka_re_q);
    k_im   = cmd_i.step_b ? ProdW'(kb_im_q) : ProdW'(ka_im_q);
    nre    = r2 - i2 + k_re;
    nim    = (ri <<< 1) + k_im;
  end

  // saturate and pick the next z
  always_comb begin
    z_re_d = z_re_q;
    z_im_d = z_im_q;
    if (cmd_i.load) begin
      z_re_d = z_real_i;
      z_im_d = z_imag_i;
    end else if (cmd_i.step_a || cmd_i.step_b) begin
      if (nre > SatMax) begin
        z_re_d = SatMax[CoordW-1:0];
      end else if (nre < SatMin) begin
        z_re_d = SatMin[CoordW-1:0];
      end else begin
        z_re_d = nre[CoordW-1:0];
      end
      if (nim > SatMax) begin
        z_im_d = SatMax[CoordW-1:0];
      end else if (nim < SatMin) begin
        z_im_d = SatMin[CoordW-1:0];
      end else begin
        z_im_d = nim[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_re_q <= z_re_d;
    z_im_q <= z_im_d;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step_b) begin
      cnt_q <= cnt_q + IterW'(1);
    end
  end

  // result code: all ones when the limit is hit, else scaled count
  assign res = (cnt_q >= max_iter_i) ? '1 : ResW'(cnt_q) * ResW'(EscScale);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_value_o = out_data_q;

  assign sts_o.lim      = cnt_q >= max_iter_i;
  assign sts_o.esc      = sq_sum >= Limit;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

FILE: rtl/core/biquadratic_julia_escape_time_unit.sv
// operation: a point is accepted only while idle, and the next point is not taken
//   until the result of the last one has been loaded into the output register
// each step is two half-steps, each a product state (three 32x32 multipliers)
//   followed by an add/saturate state
// reset: asynchronous, active low; clears control, c and d to zero and
//   max_iterations to 100; no clearing pass
module biquadratic_julia_escape_time_unit #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,  // z_real [31:0], z_imag [63:32]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // escape_value [15:0]
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bjet_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [bjet_pkg::CoordW-1:0]       cfg_wdata_i
);
  import bjet_pkg::*;

  logic signed [CoordW-1:0] d_real_q, d_imag_q, c_real_q, c_imag_q;
  logic [IterW-1:0]         max_iter_q;
  logic signed [ResW-1:0]   escape_value;
  cmd_t                     cmd;
  sts_t                     sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_real_q   <= '0;
      d_imag_q   <= '0;
      c_real_q   <= '0;
      c_imag_q   <= '0;
      max_iter_q <= MaxIterReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_D_REAL:   d_real_q   <= cfg_wdata_i;
        CFG_D_IMAG:   d_imag_q   <= cfg_wdata_i;
        CFG_C_REAL:   c_real_q   <= cfg_wdata_i;
        CFG_C_IMAG:   c_imag_q   <= cfg_wdata_i;
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[IterW-1:0];
        default: begin
        end
      endcase
    end
  end

  bjet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bjet_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .z_real_i       (s_tdata[31:0]),
    .z_imag_i       (s_tdata[63:32]),
    .d_real_i       (d_real_q),
    .d_imag_i       (d_imag_q),
    .c_real_i       (c_real_q),
    .c_imag_i       (c_imag_q),
    .max_iter_i     (max_iter_q),
    .out_valid_o    (m_tvalid),
    .out_ready_i    (m_tready),
    .escape_value_o (escape_value)
  );

  assign m_tdata = escape_value;

endmodule
